/* sv/bcdt_pkg.sv */
`default_nettype none

package bcdt_pkg;

   // mode codes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_MENU = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OVER = 2'd2;

   // preset selection
   localparam int NUM_PRESETS = 10;
   localparam int IDX_W       = 4;

   // prescaler
   localparam int PRESCALE_W     = 8;
   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd10;

   // BCD time packed as MT MO ST SO nibbles
   localparam int TIME_W = 16;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [3:0]        minutes_tens;
      logic [3:0]        minutes_ones;
      logic [2:0]        seconds_tens;
      logic [3:0]        seconds_ones;
      logic              alarm;
   } rsp_type;

   // preset times; indexes past the table read as 00:00
   function automatic logic [TIME_W-1:0] preset_value(input logic [IDX_W-1:0] idx);
      logic [TIME_W-1:0] val;
      case (idx)
         4'd0:    val = 16'h0100;
         4'd1:    val = 16'h0300;
         4'd2:    val = 16'h0500;
         4'd3:    val = 16'h0700;
         4'd4:    val = 16'h1000;
         4'd5:    val = 16'h1200;
         4'd6:    val = 16'h1500;
         4'd7:    val = 16'h2000;
         4'd8:    val = 16'h2500;
         4'd9:    val = 16'h3000;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* sv/bcdt_req_if.sv */
`default_nettype none

interface bcdt_req_if;
   logic valid;
   logic ready;
   logic tick;
   logic start_pressed;
   logic select_pressed;

   modport source (output valid, output tick, output start_pressed,
                   output select_pressed, input ready);
   modport sink   (input valid, input tick, input start_pressed,
                   input select_pressed, output ready);
endinterface

`default_nettype wire

/* sv/bcdt_rsp_if.sv */
`default_nettype none

interface bcdt_rsp_if
   import bcdt_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [3:0]        minutes_tens;
   logic [3:0]        minutes_ones;
   logic [2:0]        seconds_tens;
   logic [3:0]        seconds_ones;
   logic              alarm;

   modport source (output valid, output mode, output minutes_tens, output minutes_ones,
                   output seconds_tens, output seconds_ones, output alarm, input ready);
   modport sink   (input valid, input mode, input minutes_tens, input minutes_ones,
                   input seconds_tens, input seconds_ones, input alarm, output ready);
endinterface

`default_nettype wire

/* sv/bcdt_csr_if.sv */
`default_nettype none

interface bcdt_csr_if
   import bcdt_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [PRESCALE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/bcd_countdown_timer_controller.sv */
`default_nettype none

// channel   dir  payload                                          handshake
// req_bus   in   tick, start_pressed, select_pressed              valid/ready
// rsp_bus   out  mode, minutes/seconds BCD digits, alarm          valid/ready
// csr_bus   in   prescale_limit (8 bits)                          valid/ready
//
// One request per cycle while req_ready is high; each response is registered.
// Timer state updates in the same edge that takes the request.
// A two-entry output stage (result register plus skid) keeps req ready while
// one response waits; req_ready drops only when both entries are full.
// Synchronous active-high reset: mode menu, preset 0, digits 00:00, limit 10.

module bcd_countdown_timer_controller
   import bcdt_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   bcdt_req_if.sink    req_bus,
   bcdt_rsp_if.source  rsp_bus,
   bcdt_csr_if.sink    csr_bus
);

   // timer state
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [IDX_W-1:0]      preset_idx_ff, preset_idx_in;
   logic [TIME_W-1:0]     remaining_ff, remaining_in;
   logic [PRESCALE_W-1:0] prescale_cnt_ff, prescale_cnt_in;
   logic [TIME_W-1:0]     shown_ff, shown_in;
   logic [PRESCALE_W-1:0] limit_ff;

   // output stage
   rsp_type out_ff, skid_ff, rsp_new;
   logic    out_vld_ff, skid_vld_ff;

   logic push, pop;
   logic alarm;

   assign req_bus.ready = !skid_vld_ff;
   assign csr_bus.ready = 1'b1;
   assign push = req_bus.valid && req_bus.ready;
   assign pop  = out_vld_ff && rsp_bus.ready;

   // one-second BCD decrement with borrow
   logic [3:0]        mt, mo, st, so;
   logic [3:0]        dmt, dmo, dst, dso;
   logic              dec_borrow;
   logic [TIME_W-1:0] dec_time;

   always_comb begin
      mt = remaining_ff[15:12];
      mo = remaining_ff[11:8];
      st = remaining_ff[7:4];
      so = remaining_ff[3:0];
      dmt = mt;
      dmo = mo;
      dst = st;
      dso = so;
      dec_borrow = 1'b0;
      if (so != 4'd0) begin
         dso = so - 4'd1;
      end else if (st != 4'd0) begin
         dst = st - 4'd1;
         dso = 4'd9;
      end else begin
         dst = 4'd5;
         dso = 4'd9;
         if (mo != 4'd0) begin
            dmo = mo - 4'd1;
         end else if (mt != 4'd0) begin
            dmt = mt - 4'd1;
            dmo = 4'd9;
         end else begin
            dec_borrow = 1'b1;
         end
      end
      dec_time = dec_borrow ? '0 : {dmt, dmo, dst, dso};
   end

   // next state for one request
   logic [IDX_W:0]        idx_inc;
   logic [PRESCALE_W:0]   cnt_inc;
   logic [IDX_W-1:0]      idx_sel;

   always_comb begin
      mode_in         = mode_ff;
      preset_idx_in   = preset_idx_ff;
      remaining_in    = remaining_ff;
      prescale_cnt_in = prescale_cnt_ff;
      shown_in        = shown_ff;
      alarm           = 1'b0;
      idx_inc = {1'b0, preset_idx_ff} + {{IDX_W{1'b0}}, 1'b1};
      cnt_inc = {1'b0, prescale_cnt_ff} + {{PRESCALE_W{1'b0}}, 1'b1};
      idx_sel = (idx_inc >= (IDX_W+1)'(NUM_PRESETS)) ? '0 : idx_inc[IDX_W-1:0];
      if (push && req_bus.tick) begin
         unique case (mode_ff)
            MODE_MENU: begin
               if (req_bus.select_pressed) begin
                  preset_idx_in = idx_sel;
               end
               shown_in = preset_value(preset_idx_in);
               if (req_bus.start_pressed) begin
                  remaining_in = shown_in;
                  mode_in      = MODE_RUN;
               end
            end
            MODE_RUN: begin
               if (req_bus.select_pressed) begin
                  mode_in = MODE_MENU;
               end else if (cnt_inc > {1'b0, limit_ff}) begin
                  prescale_cnt_in = '0;
                  remaining_in    = dec_time;
                  if (dec_borrow) begin
                     mode_in = MODE_OVER;
                  end else begin
                     shown_in = dec_time;
                  end
               end else begin
                  prescale_cnt_in = cnt_inc[PRESCALE_W-1:0];
                  shown_in        = remaining_ff;
               end
            end
            MODE_OVER: begin
               if (req_bus.start_pressed || req_bus.select_pressed) begin
                  mode_in = MODE_MENU;
               end else begin
                  alarm = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response built from post-request state
   always_comb begin
      rsp_new.mode         = mode_in;
      rsp_new.minutes_tens = shown_in[15:12];
      rsp_new.minutes_ones = shown_in[11:8];
      rsp_new.seconds_tens = shown_in[6:4];
      rsp_new.seconds_ones = shown_in[3:0];
      rsp_new.alarm        = alarm;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_MENU;
         preset_idx_ff   <= '0;
         remaining_ff    <= '0;
         prescale_cnt_ff <= '0;
         shown_ff        <= '0;
         limit_ff        <= PRESCALE_RESET;
      end else begin
         mode_ff         <= mode_in;
         preset_idx_ff   <= preset_idx_in;
         remaining_ff    <= remaining_in;
         prescale_cnt_ff <= prescale_cnt_in;
         shown_ff        <= shown_in;
         if (csr_bus.valid && csr_bus.ready) begin
            limit_ff <= csr_bus.data;
         end
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (pop) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else if (!push) begin
            out_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= rsp_new;
         end
      end else if (push) begin
         if (!out_vld_ff) begin
            out_ff <= rsp_new;
         end else begin
            skid_ff <= rsp_new;
         end
      end
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.mode         = out_ff.mode;
   assign rsp_bus.minutes_tens = out_ff.minutes_tens;
   assign rsp_bus.minutes_ones = out_ff.minutes_ones;
   assign rsp_bus.seconds_tens = out_ff.seconds_tens;
   assign rsp_bus.seconds_ones = out_ff.seconds_ones;
   assign rsp_bus.alarm        = out_ff.alarm;

endmodule

`default_nettype wire

/* tb/sv/bcdt_tb_pkg.sv */
`default_nettype none

package bcdt_tb_pkg;
   import bcdt_pkg::*;

   // Tracks the timer state from accepted requests and checks the display stream
   class countdown_scoreboard;
      logic [MODE_W-1:0]     mode_q;
      logic [IDX_W-1:0]      preset_q;
      logic [TIME_W-1:0]     remaining_q;
      logic [TIME_W-1:0]     display_q;
      logic [PRESCALE_W-1:0] prescale_q;
      logic [PRESCALE_W-1:0] limit_q;
      rsp_type               expected_display[$];
      int unsigned           mismatches;
      int unsigned           requests;
      int unsigned           ticks;
      int unsigned           responses;
      int unsigned           expiries;
      int unsigned           alarm_ticks;
      int unsigned           limit_writes;

      function new();
         mode_q       = MODE_MENU;
         preset_q     = '0;
         remaining_q  = '0;
         display_q    = '0;
         prescale_q   = '0;
         limit_q      = PRESCALE_RESET;
         mismatches   = 0;
         requests     = 0;
         ticks        = 0;
         responses    = 0;
         expiries     = 0;
         alarm_ticks  = 0;
         limit_writes = 0;
      endfunction

      function void set_limit(input logic [PRESCALE_W-1:0] value);
         limit_q = value;
         limit_writes++;
      endfunction

      // preset times as MM:SS nibbles; past the table reads 00:00
      function logic [TIME_W-1:0] preset_time(input logic [IDX_W-1:0] idx);
         case (idx)
            4'd0:    return 16'h0100;
            4'd1:    return 16'h0300;
            4'd2:    return 16'h0500;
            4'd3:    return 16'h0700;
            4'd4:    return 16'h1000;
            4'd5:    return 16'h1200;
            4'd6:    return 16'h1500;
            4'd7:    return 16'h2000;
            4'd8:    return 16'h2500;
            4'd9:    return 16'h3000;
            default: return 16'h0000;
         endcase
      endfunction

      // one second down with BCD borrow; returns 1 on borrow past 00:00
      function bit count_down_second();
         logic [3:0] mt, mo, st, so;
         {mt, mo, st, so} = remaining_q;
         if (so != 0) begin
            so = so - 1;
         end else if (st != 0) begin
            st = st - 1;
            so = 4'd9;
         end else begin
            st = 4'd5;
            so = 4'd9;
            if (mo != 0) begin
               mo = mo - 1;
            end else if (mt != 0) begin
               mt = mt - 1;
               mo = 4'd9;
            end else begin
               remaining_q = '0;
               return 1'b1;
            end
         end
         remaining_q = {mt, mo, st, so};
         return 1'b0;
      endfunction

      // advance the timer by one accepted request and queue the expected display
      function void note_request(input logic tick, input logic start, input logic select);
         rsp_type want;
         int      nx;
         logic    alarm;
         requests++;
         alarm = 1'b0;
         if (tick) begin
            ticks++;
            case (mode_q)
               MODE_MENU: begin
                  // select steps first, then start loads the new preset
                  if (select) begin
                     nx = preset_q + 1;
                     preset_q = (nx >= NUM_PRESETS) ? '0 : nx[IDX_W-1:0];
                  end
                  display_q = preset_time(preset_q);
                  if (start) begin
                     remaining_q = display_q;
                     mode_q      = MODE_RUN;
                  end
               end
               MODE_RUN: begin
                  if (select) begin
                     mode_q = MODE_MENU;
                  end else begin
                     nx = prescale_q + 1;
                     if (nx > limit_q) begin
                        prescale_q = '0;
                        // on expiry the display keeps its last value
                        if (count_down_second()) begin
                           mode_q = MODE_OVER;
                           expiries++;
                        end else begin
                           display_q = remaining_q;
                        end
                     end else begin
                        prescale_q = nx[PRESCALE_W-1:0];
                        display_q  = remaining_q;
                     end
                  end
               end
               MODE_OVER: begin
                  if (start || select) begin
                     mode_q = MODE_MENU;
                  end else begin
                     alarm = 1'b1;
                     alarm_ticks++;
                  end
               end
               default: ;
            endcase
         end
         want.mode         = mode_q;
         want.minutes_tens = display_q[15:12];
         want.minutes_ones = display_q[11:8];
         want.seconds_tens = display_q[6:4];
         want.seconds_ones = display_q[3:0];
         want.alarm        = alarm;
         expected_display.push_back(want);
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("ERROR: %s", msg);
      endtask

      task compare_field(input string name, input logic [3:0] got, input logic [3:0] want);
         if (got !== want)
            report_mismatch($sformatf("response %0d: %s is %0d, expected %0d",
                                      responses, name, got, want));
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         responses++;
         if (expected_display.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing expected",
                                      responses));
            return;
         end
         want = expected_display.pop_front();
         compare_field("mode", 4'(got.mode), 4'(want.mode));
         compare_field("minutes_tens", got.minutes_tens, want.minutes_tens);
         compare_field("minutes_ones", got.minutes_ones, want.minutes_ones);
         compare_field("seconds_tens", 4'(got.seconds_tens), 4'(want.seconds_tens));
         compare_field("seconds_ones", got.seconds_ones, want.seconds_ones);
         compare_field("alarm", 4'(got.alarm), 4'(want.alarm));
      endtask
   endclass

endpackage

`default_nettype wire

/* tb/sv/bcd_countdown_timer_controller_tb.sv */
`default_nettype none

module bcd_countdown_timer_controller_tb;
   import bcdt_pkg::*;
   import bcdt_tb_pkg::*;

   localparam int PHASES   = 5;
   localparam int IDLE_PCT = 22;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcdt_req_if req_bus();
   bcdt_rsp_if rsp_bus();
   bcdt_csr_if csr_bus();

   countdown_scoreboard sb = new();

   int unsigned send_idle_pct = IDLE_PCT;
   int unsigned preset_goal   = 0;

   bcd_countdown_timer_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // 12-unit clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // offer one request after random idle cycles; note it once taken
   task automatic send_request(input logic tick, input logic start, input logic select);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.tick           <= tick;
      req_bus.start_pressed  <= start;
      req_bus.select_pressed <= select;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(tick, start, select);
   endtask

   // random request steered by the tracked mode: pick a preset, run it down,
   // silence the alarm; some noise and aborted runs mixed in
   task automatic send_random(input int unsigned abort_div);
      logic tick, start, select;
      tick   = ($urandom_range(99) >= 8);
      start  = 1'b0;
      select = 1'b0;
      case (sb.mode_q)
         MODE_MENU: begin
            if ($urandom_range(99) < 10) begin
               {start, select} = 2'($urandom_range(3));
            end else if (sb.preset_q == preset_goal) begin
               start = 1'b1;
            end else begin
               select = 1'b1;
               start  = (((sb.preset_q + 1) % NUM_PRESETS) == preset_goal) &&
                        ($urandom_range(1) == 1);
            end
         end
         MODE_RUN: begin
            select      = ($urandom_range(abort_div - 1) == 0);
            start       = 1'($urandom_range(1));   // ignored while running
            preset_goal = ($urandom_range(99) < 60) ? 0 : $urandom_range(NUM_PRESETS - 1);
         end
         default: begin
            if ($urandom_range(99) < 25)
               {start, select} = 2'($urandom_range(1, 3));
         end
      endcase
      send_request(tick, start, select);
   endtask

   task automatic write_prescale(input logic [PRESCALE_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.set_limit(value);
      csr_bus.valid <= 1'b0;
   endtask

   // stop offering and let every expected response come back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (sb.expected_display.size() != 0) @(posedge clock);
   endtask

   // response side: check, random stalls, one long hold-off, one stall-free stretch
   initial begin
      rsp_type     got;
      int unsigned seen;
      int unsigned hold_left;
      seen      = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.mode         = rsp_bus.mode;
            got.minutes_tens = rsp_bus.minutes_tens;
            got.minutes_ones = rsp_bus.minutes_ones;
            got.seconds_tens = rsp_bus.seconds_tens;
            got.seconds_ones = rsp_bus.seconds_ones;
            got.alarm        = rsp_bus.alarm;
            sb.check_response(got);
            seen++;
            if (seen == 150)
               hold_left = 60;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (seen >= 500 && seen < 650) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // stimulus
   initial begin
      int unsigned p;
      int unsigned phase_ticks;
      int unsigned tick_goal;
      int unsigned end_wait;
      logic [PRESCALE_W-1:0] lim;

      req_bus.valid          <= 1'b0;
      req_bus.tick           <= 1'b0;
      req_bus.start_pressed  <= 1'b0;
      req_bus.select_pressed <= 1'b0;
      csr_bus.valid          <= 1'b0;
      csr_bus.data           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: no tick, first menu tick, both buttons, abort from run
      send_request(1'b0, 1'b1, 1'b1);
      send_request(1'b1, 1'b0, 1'b0);
      send_request(1'b1, 1'b1, 1'b1);
      repeat (4) send_request(1'b1, 1'b0, 1'b0);
      send_request(1'b1, 1'b1, 1'b1);
      send_request(1'b0, 1'b0, 1'b1);

      // lowered limit below the running prescale count, then preset wrap
      drain_responses();
      write_prescale(8'd1);
      send_request(1'b1, 1'b1, 1'b0);
      send_request(1'b1, 1'b0, 1'b0);
      send_request(1'b1, 1'b0, 1'b0);
      send_request(1'b0, 1'b1, 1'b1);
      send_request(1'b1, 1'b0, 1'b1);
      repeat (9) send_request(1'b1, 1'b0, 1'b1);

      // random phases over several prescale limits
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin lim = 8'd0;                     phase_ticks = 280; end
            1:       begin lim = 8'd255;                   phase_ticks = 120; end
            2:       begin lim = 8'd1;                     phase_ticks = 200; end
            3:       begin lim = 8'($urandom_range(2, 12)); phase_ticks = 150; end
            default: begin lim = 8'd0;                     phase_ticks = 200; end
         endcase
         drain_responses();
         write_prescale(lim);
         send_idle_pct = (p == 2) ? 0 : IDLE_PCT;
         tick_goal = sb.ticks + phase_ticks;
         while (sb.ticks < tick_goal)
            send_random(150);
      end
      req_bus.valid <= 1'b0;

      // wait out the last responses, bounded
      end_wait = 0;
      while (sb.expected_display.size() != 0 && end_wait < 2000) begin
         @(posedge clock);
         end_wait++;
      end
      repeat (4) @(posedge clock);
      if (sb.expected_display.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived",
                                      sb.expected_display.size()));

      $display("Run covered %0d requests (%0d ticks), %0d responses checked, %0d limit writes.",
               sb.requests, sb.ticks, sb.responses, sb.limit_writes);
      $display("Countdowns expired %0d times, alarm sounded on %0d ticks, %0d mismatches.",
               sb.expiries, sb.alarm_ticks, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 300000);
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
